>>> rtl/core/hppg_pkg.sv
// Shared types, constants and helpers for the haptic pulse pattern generator.
// Used by hppg_ctrl, hppg_datapath and the top level; depends on nothing.
package hppg_pkg;

  localparam int TICK_BITS  = 16;
  localparam int AMP_BITS   = 16;
  localparam int AMP_FRAC_BITS = 12;
  localparam int DRIVE_BITS = 17;
  localparam int LEN_BITS   = 10;
  localparam int REPS_BITS  = 8;
  localparam int DIR_BITS   = 3;
  localparam int MODE_BITS  = 2;
  localparam int CFG_IDX_BITS = 1;

  // Amplitude clamp: ten volts.
  localparam logic [AMP_BITS-1:0] AMP_MAX = AMP_BITS'(10 << AMP_FRAC_BITS);

  // Diagonal gain 0.707 as 707 / 1000; the divider rounds with half the divisor.
  localparam logic [LEN_BITS-1:0] GAIN_NUM = LEN_BITS'(707);
  localparam logic [LEN_BITS-1:0] GAIN_DEN = LEN_BITS'(1000);

  // Divider: dividend width and two quotient bits per cycle.
  localparam int DIVIDEND_BITS = 26;
  localparam int DIV_CNT_BITS  = 4;
  localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS = DIV_CNT_BITS'(DIVIDEND_BITS / 2);

  // Mode codes.
  localparam logic [MODE_BITS-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_RENDER = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_PAUSE  = 2'd2;

  // Compass direction codes; the diagonals have the top bit set.
  localparam logic [DIR_BITS-1:0] DIR_W  = 3'd0;
  localparam logic [DIR_BITS-1:0] DIR_E  = 3'd1;
  localparam logic [DIR_BITS-1:0] DIR_N  = 3'd2;
  localparam logic [DIR_BITS-1:0] DIR_S  = 3'd3;
  localparam logic [DIR_BITS-1:0] DIR_NW = 3'd4;
  localparam logic [DIR_BITS-1:0] DIR_NE = 3'd5;
  localparam logic [DIR_BITS-1:0] DIR_SW = 3'd6;
  localparam logic [DIR_BITS-1:0] DIR_SE = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_TICKS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_TICKS = 1'd1;

  // Waveform sample kind of the current tick.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ZERO = 2'd0;
  localparam kind_t KIND_RAMP = 2'd1;
  localparam kind_t KIND_STEP = 2'd2;

  // Per-axis gain sign.
  typedef logic [1:0] gain_t;
  localparam gain_t GAIN_ZERO = 2'd0;
  localparam gain_t GAIN_POS  = 2'd1;
  localparam gain_t GAIN_NEG  = 2'd2;

  typedef struct packed {
    logic accept;       // latch request, step the mode machine
    logic mul_load;     // form product, load divider
    logic div_step;     // two quotient bits
    logic finish_load;  // commit scaled amplitude of a load request
    logic out_load;     // write result register
  } hppg_cmd_t;

  typedef struct packed {
    logic is_load;
    logic div_last;
  } hppg_sts_t;

  function automatic gain_t gain_x(input logic [DIR_BITS-1:0] dir);
    gain_t g;
    case (dir)
      DIR_W, DIR_NW, DIR_SW: g = GAIN_POS;
      DIR_E, DIR_NE, DIR_SE: g = GAIN_NEG;
      default:               g = GAIN_ZERO;
    endcase
    return g;
  endfunction

  function automatic gain_t gain_y(input logic [DIR_BITS-1:0] dir);
    gain_t g;
    case (dir)
      DIR_N, DIR_NW, DIR_NE: g = GAIN_POS;
      DIR_S, DIR_SW, DIR_SE: g = GAIN_NEG;
      default:               g = GAIN_ZERO;
    endcase
    return g;
  endfunction

  function automatic logic [TICK_BITS-1:0] sat_inc(input logic [TICK_BITS-1:0] v);
    return (&v) ? v : v + TICK_BITS'(1);
  endfunction

endpackage

>>> rtl/core/hppg_ctrl.sv
// Sequencer for the haptic pulse pattern generator: request handshake,
// multiply/divide sequencing and the result register's valid flag. Uses hppg_pkg.
module hppg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output hppg_pkg::hppg_cmd_t cmd,
  input  hppg_pkg::hppg_sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd             = '0;
    cmd.accept      = in_valid && in_ready;
    cmd.mul_load    = (state_r == ST_MUL);
    cmd.div_step    = (state_r == ST_DIV);
    cmd.finish_load = (state_r == ST_FIN) && sts.is_load;
    cmd.out_load    = (state_r == ST_FIN) && !sts.is_load && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd.accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_last) state_nxt = ST_FIN;
      ST_FIN:  if (sts.is_load || out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/hppg_datapath.sv
// Datapath of the haptic pulse pattern generator: config registers, mode
// machine state, 16x10 multiplier, radix-4 restoring divider, result register.
// Uses hppg_pkg.
module hppg_datapath (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  hppg_pkg::hppg_cmd_t                      cmd,
  output hppg_pkg::hppg_sts_t                      sts,
  input  logic                                     cfg_we,
  input  logic [hppg_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [hppg_pkg::LEN_BITS-1:0]            cfg_wdata,
  input  logic                                     in_command,
  input  logic [hppg_pkg::DIR_BITS-1:0]            in_direction,
  input  logic [hppg_pkg::AMP_BITS-1:0]            in_amplitude,
  input  logic [hppg_pkg::REPS_BITS-1:0]           in_repetitions,
  input  logic [hppg_pkg::TICK_BITS-1:0]           in_render_ticks,
  input  logic [hppg_pkg::TICK_BITS-1:0]           in_pause_ticks,
  output logic signed [hppg_pkg::DRIVE_BITS-1:0]   out_drive_x,
  output logic signed [hppg_pkg::DRIVE_BITS-1:0]   out_drive_y,
  output logic [hppg_pkg::MODE_BITS-1:0]           out_mode
);

  localparam int TB = hppg_pkg::TICK_BITS;
  localparam int LB = hppg_pkg::LEN_BITS;
  localparam int DB = hppg_pkg::DIVIDEND_BITS;
  localparam int OB = hppg_pkg::DRIVE_BITS;

  // Configuration
  logic [LB-1:0] ramp_r, step_r;

  // Mode machine state
  logic [hppg_pkg::MODE_BITS-1:0] mode_r, mode_nxt;
  logic                           pend_r, pend_nxt;
  logic                           seg_r, seg_nxt;
  logic [TB-1:0]                  mode_el_r, mode_el_nxt;
  logic [TB-1:0]                  wave_el_r, wave_el_nxt;
  logic [hppg_pkg::REPS_BITS-1:0] reps_r, reps_nxt;
  logic [TB-1:0]                  rlen_r, rlen_nxt;
  logic [TB-1:0]                  plen_r, plen_nxt;
  logic [hppg_pkg::AMP_BITS-1:0]  mag_r, mag_nxt;
  logic [hppg_pkg::DIR_BITS-1:0]  dir_r, dir_nxt;

  // Per-request operands
  logic                 load_r, load_nxt;
  hppg_pkg::kind_t      kind_r, kind_nxt;
  logic                 negd_r, negd_nxt;
  logic [LB-1:0]        absd_r, absd_nxt;
  logic [LB-1:0]        div_r, div_nxt;

  // Divider
  logic [DB-1:0]                     quo_r;
  logic [LB:0]                       rem_r;
  logic [hppg_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic [DB-1:0]                     prod;
  logic [LB:0]                       s1_trial, s1_rem, s2_trial, s2_rem;
  logic                              s1_ge, s2_ge;
  logic [DB-1:0]                     s1_quo;

  // Tick helpers
  logic [hppg_pkg::AMP_BITS-1:0]  amp_clamp;
  logic [LB-1:0]                  r_eff;
  logic [TB-1:0]                  wave_inc, mode_inc;
  logic signed [LB+1:0]           diff;
  logic [LB+1:0]                  diff_abs;
  logic [hppg_pkg::REPS_BITS-1:0] reps_dec;
  logic [OB-1:0]                  q_ext, m_ext;

  assign amp_clamp = (in_amplitude > hppg_pkg::AMP_MAX) ? hppg_pkg::AMP_MAX : in_amplitude;
  assign r_eff     = (ramp_r == '0) ? LB'(1) : ramp_r;
  assign wave_inc  = hppg_pkg::sat_inc(wave_el_r);
  assign mode_inc  = hppg_pkg::sat_inc(mode_el_r);
  assign diff      = $signed({2'b00, r_eff}) - $signed({1'b0, wave_inc[LB-1:0], 1'b0});
  assign diff_abs  = diff[LB+1] ? (LB+2)'(-diff) : diff;
  assign reps_dec  = reps_r - hppg_pkg::REPS_BITS'(reps_r != '0);

  always_comb begin
    mode_nxt    = mode_r;
    pend_nxt    = pend_r;
    seg_nxt     = seg_r;
    mode_el_nxt = mode_el_r;
    wave_el_nxt = wave_el_r;
    reps_nxt    = reps_r;
    rlen_nxt    = rlen_r;
    plen_nxt    = plen_r;
    mag_nxt     = mag_r;
    dir_nxt     = dir_r;
    load_nxt    = load_r;
    kind_nxt    = kind_r;
    negd_nxt    = negd_r;
    absd_nxt    = absd_r;
    div_nxt     = div_r;
    if (cmd.accept) begin
      load_nxt = in_command;
      kind_nxt = hppg_pkg::KIND_ZERO;
      negd_nxt = 1'b0;
      if (in_command) begin
        // Scale through the divider: (amp * 707 + 500) / 1000.
        dir_nxt  = in_direction;
        mag_nxt  = amp_clamp;
        reps_nxt = in_repetitions;
        rlen_nxt = in_render_ticks;
        plen_nxt = in_pause_ticks;
        pend_nxt = 1'b1;
        absd_nxt = hppg_pkg::GAIN_NUM;
        div_nxt  = hppg_pkg::GAIN_DEN;
      end else begin
        case (mode_r)
          hppg_pkg::MODE_RENDER: begin
            wave_el_nxt = wave_inc;
            if (!seg_r) begin
              if (wave_inc > TB'(r_eff)) begin
                seg_nxt     = 1'b1;
                wave_el_nxt = '0;
              end else begin
                kind_nxt = hppg_pkg::KIND_RAMP;
                negd_nxt = diff[LB+1];
                absd_nxt = diff_abs[LB-1:0];
                div_nxt  = r_eff;
              end
            end else begin
              if (wave_inc > TB'(step_r)) begin
                seg_nxt     = 1'b0;
                wave_el_nxt = '0;
              end else begin
                kind_nxt = hppg_pkg::KIND_STEP;
              end
            end
            mode_el_nxt = mode_inc;
            if (mode_inc >= rlen_r) begin
              reps_nxt = reps_dec;
              if (reps_dec == '0) begin
                mode_nxt = hppg_pkg::MODE_IDLE;
              end else begin
                mode_nxt    = hppg_pkg::MODE_PAUSE;
                mode_el_nxt = '0;
              end
            end
          end
          hppg_pkg::MODE_PAUSE: begin
            mode_el_nxt = mode_inc;
            if (mode_inc >= plen_r) begin
              mode_nxt    = hppg_pkg::MODE_RENDER;
              mode_el_nxt = '0;
              wave_el_nxt = '0;
              seg_nxt     = 1'b0;
            end
          end
          default: begin
            mode_nxt = hppg_pkg::MODE_IDLE;
            if (pend_r) begin
              pend_nxt    = 1'b0;
              mode_nxt    = hppg_pkg::MODE_RENDER;
              mode_el_nxt = '0;
              wave_el_nxt = '0;
              seg_nxt     = 1'b0;
            end
          end
        endcase
      end
    end
    if (cmd.finish_load && dir_r[hppg_pkg::DIR_BITS-1]) begin
      mag_nxt = quo_r[hppg_pkg::AMP_BITS-1:0];
    end
  end

  // Multiply, then round with half the divisor.
  assign prod = DB'(mag_r) * DB'(absd_r) + DB'(div_r[LB-1:1]);

  // Two restoring division steps per cycle.
  assign s1_trial = {rem_r[LB-1:0], quo_r[DB-1]};
  assign s1_ge    = s1_trial >= {1'b0, div_r};
  assign s1_rem   = s1_ge ? s1_trial - {1'b0, div_r} : s1_trial;
  assign s1_quo   = {quo_r[DB-2:0], s1_ge};
  assign s2_trial = {s1_rem[LB-1:0], s1_quo[DB-1]};
  assign s2_ge    = s2_trial >= {1'b0, div_r};
  assign s2_rem   = s2_ge ? s2_trial - {1'b0, div_r} : s2_trial;

  assign sts.is_load  = load_r;
  assign sts.div_last = (cnt_r == hppg_pkg::DIV_STEPS - 1'b1);

  function automatic logic [OB-1:0] drive_of(input hppg_pkg::kind_t kind,
                                             input hppg_pkg::gain_t gain,
                                             input logic negd,
                                             input logic [OB-1:0] q,
                                             input logic [OB-1:0] m);
    logic [OB-1:0] v;
    logic          neg;
    v   = '0;
    neg = (gain == hppg_pkg::GAIN_NEG);
    case (kind)
      hppg_pkg::KIND_RAMP: begin
        v   = q;
        neg = neg ^ negd;
      end
      hppg_pkg::KIND_STEP: v = m;
      default:             v = '0;
    endcase
    if (gain == hppg_pkg::GAIN_ZERO) begin
      v = '0;
    end
    return neg ? OB'(-v) : v;
  endfunction

  assign q_ext = OB'(quo_r[hppg_pkg::AMP_BITS-1:0]);
  assign m_ext = OB'(mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r    <= LB'(18);
      step_r    <= LB'(7);
      mode_r    <= hppg_pkg::MODE_IDLE;
      pend_r    <= 1'b0;
      seg_r     <= 1'b0;
      mode_el_r <= '0;
      wave_el_r <= '0;
      reps_r    <= '0;
      rlen_r    <= '0;
      plen_r    <= '0;
      mag_r     <= '0;
      dir_r     <= '0;
      load_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hppg_pkg::REG_RAMP_TICKS: ramp_r <= cfg_wdata;
          hppg_pkg::REG_STEP_TICKS: step_r <= cfg_wdata;
          default: ;
        endcase
      end
      mode_r    <= mode_nxt;
      pend_r    <= pend_nxt;
      seg_r     <= seg_nxt;
      mode_el_r <= mode_el_nxt;
      wave_el_r <= wave_el_nxt;
      reps_r    <= reps_nxt;
      rlen_r    <= rlen_nxt;
      plen_r    <= plen_nxt;
      mag_r     <= mag_nxt;
      dir_r     <= dir_nxt;
      load_r    <= load_nxt;
      if (cmd.mul_load) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    negd_r <= negd_nxt;
    absd_r <= absd_nxt;
    div_r  <= div_nxt;
    if (cmd.mul_load) begin
      quo_r <= prod;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {s1_quo[DB-2:0], s2_ge};
      rem_r <= s2_rem;
    end
    if (cmd.out_load) begin
      out_drive_x <= drive_of(kind_r, hppg_pkg::gain_x(dir_r), negd_r, q_ext, m_ext);
      out_drive_y <= drive_of(kind_r, hppg_pkg::gain_y(dir_r), negd_r, q_ext, m_ext);
      out_mode    <= mode_r;
    end
  end

endmodule

>>> rtl/core/haptic_pulse_pattern_generator_top.sv
// Top level of the two-actuator haptic pulse pattern generator.
// Instantiates hppg_ctrl and hppg_datapath; uses hppg_pkg.
//
// Usage:
//   Input channel (in_*): one request per handshake. in_command = 1 loads a
//   pattern (direction, amplitude, repetitions, render and pause lengths) and
//   raises a start request; it returns no result. in_command = 0 is one time
//   tick; it steps the idle/render/pause machine and returns exactly one result.
//   Result channel (out_*): drive_x, drive_y (signed, volts * 4096) and the
//   mode after the tick.
//   Config port (cfg_*): write ramp_ticks (index 0) or step_ticks (index 1)
//   while no request is in flight; takes effect at once.
//   Sequence: each accepted request passes the multiply state, then the shared
//   radix-4 divider (ramp slope, or the 0.707 diagonal gain on a load), then
//   the commit state; the next request is taken only once it is back in idle.
//   A tick's result is written in the commit state once the register is free.
//   Stall: a finished result sits in the output register; the next request is
//   still taken, and its own result waits in the divider until out_ready frees
//   the register.
//   Reset (rst_n low, synchronous): idle, no pending start, ramp_ticks 18,
//   step_ticks 7, no result valid.
module haptic_pulse_pattern_generator_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_command,
  input  logic [hppg_pkg::DIR_BITS-1:0]           in_direction,
  input  logic [hppg_pkg::AMP_BITS-1:0]           in_amplitude,
  input  logic [hppg_pkg::REPS_BITS-1:0]          in_repetitions,
  input  logic [hppg_pkg::TICK_BITS-1:0]          in_render_ticks,
  input  logic [hppg_pkg::TICK_BITS-1:0]          in_pause_ticks,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [hppg_pkg::DRIVE_BITS-1:0]  out_drive_x,
  output logic signed [hppg_pkg::DRIVE_BITS-1:0]  out_drive_y,
  output logic [hppg_pkg::MODE_BITS-1:0]          out_mode,
  input  logic                                    cfg_we,
  input  logic [hppg_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [hppg_pkg::LEN_BITS-1:0]           cfg_wdata
);

  hppg_pkg::hppg_cmd_t cmd;
  hppg_pkg::hppg_sts_t sts;

  // Sequencing: handshake, multiply/divide steps, result valid.
  hppg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // State, arithmetic and result payload.
  hppg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_direction    (in_direction),
    .in_amplitude    (in_amplitude),
    .in_repetitions  (in_repetitions),
    .in_render_ticks (in_render_ticks),
    .in_pause_ticks  (in_pause_ticks),
    .out_drive_x     (out_drive_x),
    .out_drive_y     (out_drive_y),
    .out_mode        (out_mode)
  );

  // Busy right after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in flight");

  // A load request never writes the result register.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.is_load)
    else $error("result written for a load request");

  // Result valid rises only from a result write.
  a_valid_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without a result write");

  // Committing a load returns straight to ready.
  a_load_commit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish_load |=> in_ready)
    else $error("not ready after load commit");

endmodule
